[design/cabc_pkg.sv]
// ---------------------------------------------------------------------------
// cabc_pkg
// shared types, constants and helpers of the clipped alpha blend compositor
// ---------------------------------------------------------------------------
package cabc_pkg;

  localparam int MAX_DIM_DEF    = 4096;
  localparam int FIFO_DEPTH_DEF = 2;

  localparam int COORD_W  = 12;
  localparam int OFFSET_W = 14;
  localparam int DIM_W    = 13;
  localparam int ALPHA_W  = 8;
  localparam int PIXEL_W  = 32;
  localparam int RGB_W    = 24;
  localparam int PROD_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int LIM_W    = 16;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET  = '0;
  localparam logic [DIM_W-1:0]    DIM_RESET     = 13'd4096;
  localparam logic [ALPHA_W-1:0]  OPACITY_RESET = 8'hFF;
  localparam logic [ALPHA_W-1:0]  ALPHA_FULL    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X      = 3'd0,
    CFG_OFFSET_Y      = 3'd1,
    CFG_TARGET_WIDTH  = 3'd2,
    CFG_TARGET_HEIGHT = 3'd3,
    CFG_OPACITY_LEVEL = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                in_range;
    logic [COORD_W-1:0]  dst_col;
    logic [COORD_W-1:0]  dst_row;
    logic [PROD_W-1:0]   alpha_prod;
    logic [RGB_W-1:0]    src_rgb;
    logic [RGB_W-1:0]    dst_rgb;
  } item_t;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic logic [ALPHA_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W-1:0] t;
    t = x + 16'd1 + {8'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

[design/cabc_if.sv]
// ---------------------------------------------------------------------------
// cabc channel interfaces
// valid/ready channels for pixel input, blend result and register writes
// ---------------------------------------------------------------------------
interface cabc_in_if;
  logic                         valid;
  logic                         ready;
  logic [cabc_pkg::COORD_W-1:0] src_col;
  logic [cabc_pkg::COORD_W-1:0] src_row;
  logic [cabc_pkg::PIXEL_W-1:0] src_argb;
  logic [cabc_pkg::PIXEL_W-1:0] dst_pixel;
  modport source (output valid, src_col, src_row, src_argb, dst_pixel, input ready);
  modport sink   (input valid, src_col, src_row, src_argb, dst_pixel, output ready);
endinterface

interface cabc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         write_enable;
  logic [cabc_pkg::COORD_W-1:0] dst_col;
  logic [cabc_pkg::COORD_W-1:0] dst_row;
  logic [cabc_pkg::PIXEL_W-1:0] out_pixel;
  modport source (output valid, write_enable, dst_col, dst_row, out_pixel, input ready);
  modport sink   (input valid, write_enable, dst_col, dst_row, out_pixel, output ready);
endinterface

interface cabc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cabc_pkg::CFG_IDX_W-1:0]  index;
  logic [cabc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/cabc_front.sv]
// ---------------------------------------------------------------------------
// cabc_front
// register file, placement, clipping and opacity product of each beat
// ---------------------------------------------------------------------------
module cabc_front #(
  parameter int MAX_DIM = cabc_pkg::MAX_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  cabc_in_if.sink             in_ch,
  cabc_cfg_if.sink            cfg_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output cabc_pkg::item_t     push_item
);

  logic [cabc_pkg::OFFSET_W-1:0] off_x_r, off_x_nxt;
  logic [cabc_pkg::OFFSET_W-1:0] off_y_r, off_y_nxt;
  logic [cabc_pkg::DIM_W-1:0]    tgt_w_r, tgt_w_nxt;
  logic [cabc_pkg::DIM_W-1:0]    tgt_h_r, tgt_h_nxt;
  logic [cabc_pkg::ALPHA_W-1:0]  opac_r, opac_nxt;

  logic                          vld_r, vld_nxt;
  cabc_pkg::item_t               item_r, item_nxt;

  logic [cabc_pkg::OFFSET_W:0]   dx, dy;
  logic [cabc_pkg::LIM_W-1:0]    lim_w, lim_h;
  logic                          in_acc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !vld_r || push_ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    off_x_nxt = off_x_r;
    off_y_nxt = off_y_r;
    tgt_w_nxt = tgt_w_r;
    tgt_h_nxt = tgt_h_r;
    opac_nxt  = opac_r;
    if (cfg_ch.valid) begin
      case (cabc_pkg::cfg_idx_t'(cfg_ch.index))
        cabc_pkg::CFG_OFFSET_X:      off_x_nxt = cfg_ch.data;
        cabc_pkg::CFG_OFFSET_Y:      off_y_nxt = cfg_ch.data;
        cabc_pkg::CFG_TARGET_WIDTH:  tgt_w_nxt = cfg_ch.data[cabc_pkg::DIM_W-1:0];
        cabc_pkg::CFG_TARGET_HEIGHT: tgt_h_nxt = cfg_ch.data[cabc_pkg::DIM_W-1:0];
        cabc_pkg::CFG_OPACITY_LEVEL: opac_nxt  = cfg_ch.data[cabc_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // signed placement, one bit wider than the offset
  always_comb begin
    dx = {off_x_r[cabc_pkg::OFFSET_W-1], off_x_r} + {3'b000, in_ch.src_col};
    dy = {off_y_r[cabc_pkg::OFFSET_W-1], off_y_r} + {3'b000, in_ch.src_row};
    lim_w = ({3'b000, tgt_w_r} > cabc_pkg::LIM_W'(MAX_DIM)) ?
            cabc_pkg::LIM_W'(MAX_DIM) : {3'b000, tgt_w_r};
    lim_h = ({3'b000, tgt_h_r} > cabc_pkg::LIM_W'(MAX_DIM)) ?
            cabc_pkg::LIM_W'(MAX_DIM) : {3'b000, tgt_h_r};
  end

  always_comb begin
    item_nxt = item_r;
    vld_nxt  = vld_r;
    if (in_acc) begin
      vld_nxt           = 1'b1;
      item_nxt.in_range = !dx[cabc_pkg::OFFSET_W] && !dy[cabc_pkg::OFFSET_W] &&
                          ({1'b0, dx} < lim_w) && ({1'b0, dy} < lim_h);
      item_nxt.dst_col  = dx[cabc_pkg::COORD_W-1:0];
      item_nxt.dst_row  = dy[cabc_pkg::COORD_W-1:0];
      item_nxt.alpha_prod = cabc_pkg::PROD_W'(in_ch.src_argb[31:24]) *
                            cabc_pkg::PROD_W'(opac_r);
      item_nxt.src_rgb  = in_ch.src_argb[cabc_pkg::RGB_W-1:0];
      item_nxt.dst_rgb  = in_ch.dst_pixel[cabc_pkg::RGB_W-1:0];
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= cabc_pkg::OFFSET_RESET;
      off_y_r <= cabc_pkg::OFFSET_RESET;
      tgt_w_r <= cabc_pkg::DIM_RESET;
      tgt_h_r <= cabc_pkg::DIM_RESET;
      opac_r  <= cabc_pkg::OPACITY_RESET;
      vld_r   <= 1'b0;
    end else begin
      off_x_r <= off_x_nxt;
      off_y_r <= off_y_nxt;
      tgt_w_r <= tgt_w_nxt;
      tgt_h_r <= tgt_h_nxt;
      opac_r  <= opac_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign push_valid = vld_r;
  assign push_item  = item_r;

endmodule

[design/cabc_fifo.sv]
// ---------------------------------------------------------------------------
// cabc_fifo
// short queue between the classifying front and the blending back
// ---------------------------------------------------------------------------
module cabc_fifo #(
  parameter int DEPTH = cabc_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  cabc_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cabc_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cabc_pkg::item_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill beyond depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue fill not raised by lone push");

  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue fill not lowered by lone pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

[design/cabc_back.sv]
// ---------------------------------------------------------------------------
// cabc_back
// three stage blend pipeline: effective alpha, channel mix, divide and pack
// ---------------------------------------------------------------------------
module cabc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  cabc_pkg::item_t pop_item,
  cabc_out_if.source      out_ch
);

  logic                            v1_r, v2_r, v3_r;
  logic                            adv1, adv2, adv3;

  logic                            we1_r, we2_r;
  logic [cabc_pkg::COORD_W-1:0]    col1_r, row1_r, col2_r, row2_r;
  logic [cabc_pkg::ALPHA_W-1:0]    a1_r;
  logic [cabc_pkg::RGB_W-1:0]      s1_r, d1_r;
  logic [cabc_pkg::PROD_W-1:0]     sum2_r [3];

  logic                            we3_r;
  logic [cabc_pkg::COORD_W-1:0]    col3_r, row3_r;
  logic [cabc_pkg::PIXEL_W-1:0]    pix3_r;

  logic [cabc_pkg::ALPHA_W-1:0]    a_eff;
  logic [cabc_pkg::ALPHA_W-1:0]    a_inv;
  logic [cabc_pkg::PROD_W-1:0]     sum_nxt [3];
  logic [cabc_pkg::ALPHA_W-1:0]    ch_q [3];

  assign adv3      = !v3_r || out_ch.ready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign pop_ready = adv1;

  assign a_eff = cabc_pkg::div255(pop_item.alpha_prod);
  assign a_inv = cabc_pkg::ALPHA_FULL - a1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = cabc_pkg::PROD_W'(s1_r[8*i +: 8]) * cabc_pkg::PROD_W'(a1_r) +
                   cabc_pkg::PROD_W'(d1_r[8*i +: 8]) * cabc_pkg::PROD_W'(a_inv);
      ch_q[i]    = cabc_pkg::div255(sum2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= pop_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      we1_r  <= pop_item.in_range && (a_eff != '0);
      col1_r <= pop_item.dst_col;
      row1_r <= pop_item.dst_row;
      a1_r   <= a_eff;
      s1_r   <= pop_item.src_rgb;
      d1_r   <= pop_item.dst_rgb;
    end
    if (adv2) begin
      we2_r  <= we1_r;
      col2_r <= col1_r;
      row2_r <= row1_r;
      for (int i = 0; i < 3; i++) begin
        sum2_r[i] <= sum_nxt[i];
      end
    end
    if (adv3) begin
      we3_r  <= we2_r;
      col3_r <= we2_r ? col2_r : '0;
      row3_r <= we2_r ? row2_r : '0;
      pix3_r <= we2_r ? {cabc_pkg::ALPHA_FULL, ch_q[2], ch_q[1], ch_q[0]} : '0;
    end
  end

  assign out_ch.valid        = v3_r;
  assign out_ch.write_enable = we3_r;
  assign out_ch.dst_col      = col3_r;
  assign out_ch.dst_row      = row3_r;
  assign out_ch.out_pixel    = pix3_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_ch.ready |=> v3_r && $stable(pix3_r) && $stable(we3_r))
    else $error("result beat changed under stall");

  a_alpha_full: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && we3_r |-> pix3_r[31:24] == cabc_pkg::ALPHA_FULL)
    else $error("written beat without opaque alpha");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !we3_r |-> (pix3_r == '0) && (col3_r == '0) && (row3_r == '0))
    else $error("skipped beat with non-zero fields");

endmodule

[design/clipped_alpha_blend_compositor_core.sv]
// ---------------------------------------------------------------------------
// clipped_alpha_blend_compositor_core
// source-over compositor, clipping and global opacity, if unstalled one pixel a clock
// ---------------------------------------------------------------------------
// latency: front register, queue, three blend stages from input to result beat
// throughput: one pixel per clock if unstalled, set by three stage blend pipeline
// front register and a two entry queue let either side stall on its own
// register writes take effect in the next cycle, cfg_ch.ready is always high
// synchronous active-low reset: registers to defaults, pipeline and queue empty
// ---------------------------------------------------------------------------
module clipped_alpha_blend_compositor_core #(
  parameter int MAX_DIM    = cabc_pkg::MAX_DIM_DEF,
  parameter int FIFO_DEPTH = cabc_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cabc_in_if.sink     in_ch,
  cabc_out_if.source  out_ch,
  cabc_cfg_if.sink    cfg_ch
);

  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;
  cabc_pkg::item_t push_item, pop_item;

  cabc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  cabc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  cabc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the clipped alpha blend compositor core: a table of
// directed pixels and register writes, then randomised register settings with
// pixels mostly aimed at the target area, both channels stalling in bursts.
// every result beat is checked against a table entry or a blend predictor kept
// in step with the registers written through the configuration channel.
// ---------------------------------------------------------------------------
module tb_top;
  import cabc_pkg::*;

  localparam int MAX_DIM    = MAX_DIM_DEF;
  localparam int FULL       = 255;
  localparam int WDOG_LIMIT = 1000;
  localparam int SETTLE_CYC = 8;
  localparam int N_PHASES   = 10;
  localparam int PHASE_LEN  = 40;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] src;
    logic [PIXEL_W-1:0] dst;
  } pix_in_t;

  typedef struct packed {
    logic               we;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] pix;
  } blend_res_t;

  typedef struct packed {
    logic                  wr;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    pix_in_t               px;
    logic                  typed;
    blend_res_t            want;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b0, CFG_OFFSET_X, 14'h0000, '{12'h000, 12'h000, 32'hFF123456, 32'h00ABCDEF},
      1'b1, '{1'b1, 12'h000, 12'h000, 32'hFF123456}},
    '{1'b0, CFG_OFFSET_X, 14'h0000, '{12'hFFF, 12'hFFF, 32'hFFFFFFFF, 32'h00000000},
      1'b1, '{1'b1, 12'hFFF, 12'hFFF, 32'hFFFFFFFF}},
    '{1'b0, CFG_OFFSET_X, 14'h0000, '{12'h005, 12'h007, 32'h00FFFFFF, 32'hFFFFFFFF},
      1'b1, '0},
    '{1'b0, CFG_OFFSET_X, 14'h0000, '{12'h00A, 12'h014, 32'h80FF0000, 32'h000000FF},
      1'b0, '0},
    '{1'b0, CFG_OFFSET_X, 14'h0000, '{12'h001, 12'h002, 32'h01808080, 32'h7F7F7F7F},
      1'b0, '0},
    '{1'b1, CFG_OPACITY_LEVEL, 14'h0000, '{12'h003, 12'h003, 32'hFFFFFFFF, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_OPACITY_LEVEL, 14'h0001, '{12'h003, 12'h003, 32'hFFFFFFFF, 32'h12345678},
      1'b0, '0},
    '{1'b0, CFG_OFFSET_X, 14'h0000, '{12'h003, 12'h003, 32'hFEFFFFFF, 32'h12345678},
      1'b1, '0},
    '{1'b1, CFG_OPACITY_LEVEL, 14'h0080, '{12'h064, 12'h0C8, 32'hFF00FF00, 32'h00FF00FF},
      1'b0, '0},
    '{1'b1, CFG_OPACITY_LEVEL, 14'h00FF, '{12'h064, 12'h0C8, 32'h7F336699, 32'hAA996633},
      1'b0, '0},
    '{1'b1, CFG_OFFSET_X, 14'h3FFF, '{12'h000, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b0, CFG_OFFSET_X, 14'h0000, '{12'h001, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '{1'b1, 12'h000, 12'h000, 32'hFF010203}},
    '{1'b1, CFG_OFFSET_X, 14'h2000, '{12'hFFF, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_OFFSET_X, 14'h1FFF, '{12'h000, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_OFFSET_X, 14'h0001, '{12'hFFE, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '{1'b1, 12'hFFF, 12'h000, 32'hFF010203}},
    '{1'b1, CFG_TARGET_WIDTH, 14'h1FFF, '{12'hFFF, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_TARGET_WIDTH, 14'h0000, '{12'h000, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_TARGET_WIDTH, 14'h0002, '{12'h000, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '{1'b1, 12'h001, 12'h000, 32'hFF010203}},
    '{1'b0, CFG_OFFSET_X, 14'h0000, '{12'h001, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_OFFSET_Y, 14'h2000, '{12'h000, 12'hFFF, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_OFFSET_Y, 14'h0FFF, '{12'h000, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '{1'b1, 12'h001, 12'hFFF, 32'hFF010203}},
    '{1'b1, CFG_TARGET_HEIGHT, 14'h0000, '{12'h000, 12'h000, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_TARGET_HEIGHT, 14'h1FFF, '{12'h000, 12'h001, 32'hFF010203, 32'h0},
      1'b1, '0},
    '{1'b1, CFG_TARGET_HEIGHT, 14'h1000, '{12'h000, 12'h000, 32'hFF010203, 32'h5A5A5A5A},
      1'b1, '{1'b1, 12'h001, 12'hFFF, 32'hFF010203}}
  };

  logic clk;
  logic rst_n;

  cabc_in_if  in_ch ();
  cabc_out_if out_ch ();
  cabc_cfg_if cfg_ch ();

  clipped_alpha_blend_compositor_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic signed [OFFSET_W-1:0] sh_off_x;
  logic signed [OFFSET_W-1:0] sh_off_y;
  logic [DIM_W-1:0]           sh_width;
  logic [DIM_W-1:0]           sh_height;
  logic [ALPHA_W-1:0]         sh_opacity;

  blend_res_t blend_q [$];
  int         err_cnt = 0;
  int         idle_cnt = 0;
  bit         calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clip_dim(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] d, input int a);
    int v;
    v = (int'(s) * a + int'(d) * (FULL - a)) / FULL;
    return v[7:0];
  endfunction

  function automatic blend_res_t blend_predict(input pix_in_t p);
    blend_res_t res;
    int dx;
    int dy;
    int a;
    res = '0;
    dx = sh_off_x;
    dy = sh_off_y;
    dx = dx + int'({1'b0, p.col});
    dy = dy + int'({1'b0, p.row});
    if (dx < 0 || dy < 0 || dx >= clip_dim(sh_width) || dy >= clip_dim(sh_height))
      return res;
    a = int'(p.src[31:24]) * int'(sh_opacity) / FULL;
    if (a == 0)
      return res;
    res.we  = 1'b1;
    res.col = dx[COORD_W-1:0];
    res.row = dy[COORD_W-1:0];
    res.pix = {ALPHA_FULL, mix8(p.src[23:16], p.dst[23:16], a),
               mix8(p.src[15:8], p.dst[15:8], a), mix8(p.src[7:0], p.dst[7:0], a)};
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 14'h2000;
      2:       return 14'h1FFF;
      3:       return CFG_DATA_W'(int'($urandom_range(0, 600)) - 300);
      default: return CFG_DATA_W'($urandom_range(0, 16383));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 14'd4096;
      1:       return 14'd1;
      2:       return 14'h1FFF;
      3:       return 14'd0;
      4, 5:    return CFG_DATA_W'($urandom_range(1, 64));
      default: return CFG_DATA_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_opacity();
    case ($urandom_range(0, 7))
      0:       return 14'd0;
      1:       return 14'd1;
      2, 3:    return 14'd255;
      default: return CFG_DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  // most pixels land in or just around the target area
  function automatic pix_in_t gen_pixel();
    pix_in_t p;
    int      pos;
    int      c;
    int      ox;
    int      oy;
    p.col = COORD_W'($urandom);
    p.row = COORD_W'($urandom);
    p.src = $urandom;
    p.dst = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      ox = sh_off_x;
      oy = sh_off_y;
      pos = int'($urandom_range(0, clip_dim(sh_width) + 1)) - 1;
      c = pos - ox;
      if (c >= 0 && c < MAX_DIM) p.col = COORD_W'(c);
      pos = int'($urandom_range(0, clip_dim(sh_height) + 1)) - 1;
      c = pos - oy;
      if (c >= 0 && c < MAX_DIM) p.row = COORD_W'(c);
      case ($urandom_range(0, 5))
        0:       p.src[31:24] = 8'h00;
        1:       p.src[31:24] = 8'hFF;
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_OFFSET_X:      sh_off_x   = val;
      CFG_OFFSET_Y:      sh_off_y   = val;
      CFG_TARGET_WIDTH:  sh_width   = val[DIM_W-1:0];
      CFG_TARGET_HEIGHT: sh_height  = val[DIM_W-1:0];
      CFG_OPACITY_LEVEL: sh_opacity = val[ALPHA_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every pending blend has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (blend_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic send_pixel(input pix_in_t p, input logic typed, input blend_res_t want);
    in_ch.valid     <= 1'b1;
    in_ch.src_col   <= p.col;
    in_ch.src_row   <= p.row;
    in_ch.src_argb  <= p.src;
    in_ch.dst_pixel <= p.dst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    blend_q.push_back(typed ? want : blend_predict(p));
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // receiver stalls in bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    blend_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (blend_q.size() == 0) begin
        $display("%0t unexpected result beat: exp none got we=%b col=%h row=%h pix=%h",
                 $time, out_ch.write_enable, out_ch.dst_col, out_ch.dst_row, out_ch.out_pixel);
        err_cnt++;
      end else begin
        want = blend_q.pop_front();
        if (out_ch.write_enable !== want.we) begin
          $display("%0t write_enable: exp %b got %b", $time, want.we, out_ch.write_enable);
          err_cnt++;
        end
        if (out_ch.dst_col !== want.col) begin
          $display("%0t dst_col: exp %h got %h", $time, want.col, out_ch.dst_col);
          err_cnt++;
        end
        if (out_ch.dst_row !== want.row) begin
          $display("%0t dst_row: exp %h got %h", $time, want.row, out_ch.dst_row);
          err_cnt++;
        end
        if (out_ch.out_pixel !== want.pix) begin
          $display("%0t out_pixel: exp %h got %h", $time, want.pix, out_ch.out_pixel);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    wait (idle_cnt >= WDOG_LIMIT);
    $display("%0t watchdog: no beat for %0d cycles", $time, WDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    calm     = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.src_col   <= '0;
    in_ch.src_row   <= '0;
    in_ch.src_argb  <= '0;
    in_ch.dst_pixel <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_OFFSET_X;
    cfg_ch.data     <= '0;
    sh_off_x   = OFFSET_RESET;
    sh_off_y   = OFFSET_RESET;
    sh_width   = DIM_RESET;
    sh_height  = DIM_RESET;
    sh_opacity = OPACITY_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].wr) begin
        drain();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
      end
      send_pixel(DIR_TAB[i].px, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(CFG_OFFSET_X, '0);
        write_reg(CFG_OFFSET_Y, '0);
        write_reg(CFG_TARGET_WIDTH, 14'd4096);
        write_reg(CFG_TARGET_HEIGHT, 14'd4096);
        write_reg(CFG_OPACITY_LEVEL, 14'd255);
      end else begin
        write_reg(CFG_OFFSET_X, pick_offset());
        write_reg(CFG_OFFSET_Y, pick_offset());
        write_reg(CFG_TARGET_WIDTH, pick_dim());
        write_reg(CFG_TARGET_HEIGHT, pick_dim());
        write_reg(CFG_OPACITY_LEVEL, pick_opacity());
      end
      // last phase runs with no stalls on either side
      if (ph == N_PHASES - 1) calm = 1'b1;
      for (int k = 0; k < PHASE_LEN; k++)
        send_pixel(gen_pixel(), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (blend_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC * 4) @(posedge clk);
    if (blend_q.size() != 0)
      $display("%0t %0d results still outstanding", $time, blend_q.size());
    if (err_cnt == 0 && blend_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/cabc_pkg.sv
design/cabc_if.sv
design/cabc_front.sv
design/cabc_fifo.sv
design/cabc_back.sv
design/clipped_alpha_blend_compositor_core.sv
bench/tb_top.sv
